### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl modules
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/esp_pkg.sv
// shared types and constants of the encoder speed estimator
// no dependencies
package esp_pkg;

	localparam int REQ_W   = 2;
	localparam int TS_W    = 32;
	localparam int REG_W   = 20;
	localparam int SPEED_W = 21;
	localparam int CFG_IDX_W = 2;

	// speed scale: microseconds per second
	localparam logic [REG_W-1:0] SPEED_SCALE    = 20'd1000000;
	localparam logic [REG_W-1:0] THRESH_RESET   = 20'd800;
	localparam logic [REG_W-1:0] DEADBAND_RESET = 20'd100;

	// request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_EDGE  = 2'd0,
		REQ_START = 2'd1,
		REQ_STOP  = 2'd2
	} req_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESH   = 2'd0,
		CFG_DEADBAND = 2'd1
	} cfg_idx_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### hw/rtl/esp_if.sv
// valid/ready channel interfaces: event, result and configuration write
// depends on esp_pkg
interface esp_evt_if;
	logic                        valid;
	logic                        ready;
	logic [esp_pkg::REQ_W-1:0]   req_type;
	logic [esp_pkg::TS_W-1:0]    timestamp_us;
	logic                        dir_level;

	modport source (output valid, req_type, timestamp_us, dir_level, input ready);
	modport sink   (input valid, req_type, timestamp_us, dir_level, output ready);
endinterface

interface esp_res_if;
	logic                               valid;
	logic                               ready;
	logic signed [esp_pkg::SPEED_W-1:0] speed_pps;
	logic signed [esp_pkg::SPEED_W-1:0] speed_deadbanded;
	logic signed [esp_pkg::SPEED_W-1:0] average_pps;
	logic [esp_pkg::TS_W-1:0]           tau_us;
	logic                               tau_captured;

	modport source (output valid, speed_pps, speed_deadbanded, average_pps, tau_us,
		tau_captured, input ready);
	modport sink   (input valid, speed_pps, speed_deadbanded, average_pps, tau_us,
		tau_captured, output ready);
endinterface

interface esp_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [esp_pkg::CFG_IDX_W-1:0]   index;
	logic [esp_pkg::REG_W-1:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/encoder_speed_estimator.sv
// encoder speed estimator top level: sequencer, state and result register
// depends on esp_pkg, esp_if, esp_div, esp_ring and assert_macros.svh
//
// Usage:
//   evt carries one event word: req_type (edge, start, stop), timestamp_us
//   and dir_level. res returns exactly one result word per event. cfg writes
//   the speed threshold (index 0) and dead band (index 1); cfg is always
//   ready and must only be written while the block is idle.
//   An edge runs two divisions on one shared restoring divider, one quotient
//   bit per cycle: 1000000 / period, then |window sum| / (RING_DEPTH-1).
//   The divider takes SUM_W = 21 + clog2(RING_DEPTH) bit dividends. An edge
//   passes the speed division, the sum update, the average division and
//   the done state before its result is registered; a start, stop or unused
//   code goes straight to the done state. evt is ready only between events.
//   The result sits in an output register, so the next event is accepted
//   while a result still waits; a stalled receiver holds the sequencer only
//   when a second result is ready to load.
//   Reset clears the sequencer state, the ring valid bits and the result valid
//   flag, and loads the register reset values; no clearing pass is needed.
`include "assert_macros.svh"

module encoder_speed_estimator #(
	parameter int RING_DEPTH  = 10,
	parameter int PERIOD_BITS = 16
) (
	input logic    clk,
	input logic    arst_n,
	esp_evt_if.sink   evt,
	esp_res_if.source res,
	esp_cfg_if.sink   cfg
);

	localparam int SPEED_W = esp_pkg::SPEED_W;
	localparam int REG_W   = esp_pkg::REG_W;
	localparam int TS_W    = esp_pkg::TS_W;
	localparam int HEAD_W  = $clog2(RING_DEPTH);
	localparam int SUM_W   = SPEED_W + $clog2(RING_DEPTH);
	localparam logic [HEAD_W-1:0] LAST = HEAD_W'(RING_DEPTH - 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SPD  = 5'b00010,
		S_SUM  = 5'b00100,
		S_AVG  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;

	logic [REG_W-1:0]          thresh_q;
	logic [REG_W-1:0]          deadband_q;
	logic [TS_W-1:0]           last_edge_q;
	logic [TS_W-1:0]           start_q;
	logic [TS_W-1:0]           ts_q;
	logic [TS_W-1:0]           tau_q;
	logic                      tau_done_q;
	logic                      dir_q;
	logic [HEAD_W-1:0]         head_q;
	logic signed [SPEED_W-1:0] newest_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [SPEED_W-1:0] avg_q;

	logic                      out_vld_q;
	logic signed [SPEED_W-1:0] out_spd_q;
	logic signed [SPEED_W-1:0] out_db_q;
	logic signed [SPEED_W-1:0] out_avg_q;
	logic [TS_W-1:0]           out_tau_q;
	logic                      out_tau_done_q;

	logic                      accept;
	logic                      is_edge;
	logic [HEAD_W-1:0]         head_nxt;
	logic [HEAD_W-1:0]         oldest;
	logic [TS_W-1:0]           ts_diff;
	logic [PERIOD_BITS-1:0]    per_raw;
	logic [PERIOD_BITS-1:0]    per_fix;
	logic                      sum_neg;
	logic [SUM_W-1:0]          sum_abs;
	logic                      div_start;
	logic [SUM_W-1:0]          div_dvd;
	logic [PERIOD_BITS-1:0]    div_dvs;
	esp_pkg::div_stat_t        div_stat;
	logic [SUM_W-1:0]          div_quo;
	logic [REG_W-1:0]          mag;
	logic signed [SPEED_W-1:0] mag_s;
	logic signed [SPEED_W-1:0] spd_new;
	logic signed [SPEED_W-1:0] ring_old;
	logic                      ring_wr;
	logic [SPEED_W-1:0]        newest_abs;
	logic                      below_db;
	logic signed [SPEED_W-1:0] avg_mag;
	logic                      out_free;

	// handshakes
	assign evt.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign accept    = evt.valid && evt.ready;
	assign is_edge   = (evt.req_type == esp_pkg::REQ_EDGE);
	assign out_free  = !out_vld_q || res.ready;

	// ring pointers: next head and the entry leaving the window
	assign head_nxt = (head_q >= LAST) ? '0 : head_q + HEAD_W'(1);
	assign oldest   = (head_nxt == LAST) ? '0 : head_nxt + HEAD_W'(1);

	// period since last edge, zero counts as one
	assign ts_diff = evt.timestamp_us - last_edge_q;
	assign per_raw = ts_diff[PERIOD_BITS-1:0];
	assign per_fix = (per_raw == '0) ? PERIOD_BITS'(1) : per_raw;

	// window sum magnitude for the average division
	assign sum_neg = sum_q[SUM_W-1];
	assign sum_abs = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	// divider operand select
	assign div_start = (accept && is_edge) || (state_q == S_SUM);
	assign div_dvd   = (state_q == S_SUM) ? sum_abs : SUM_W'(esp_pkg::SPEED_SCALE);
	assign div_dvs   = (state_q == S_SUM) ? PERIOD_BITS'(RING_DEPTH - 1) : per_fix;

	esp_div #(
		.DVD_W (SUM_W),
		.DVS_W (PERIOD_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// signed speed of the edge
	assign mag     = div_quo[REG_W-1:0];
	assign mag_s   = $signed({1'b0, mag});
	assign spd_new = dir_q ? mag_s : -mag_s;
	assign ring_wr = (state_q == S_SPD) && div_stat.done;

	esp_ring #(
		.DEPTH  (RING_DEPTH),
		.ADDR_W (HEAD_W)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ring_wr),
		.wr_addr (head_q),
		.wr_data (spd_new),
		.rd_en   (accept && is_edge),
		.rd_addr (oldest),
		.rd_data (ring_old)
	);

	// average from the second division
	assign avg_mag = $signed(div_quo[SPEED_W-1:0]);

	// dead band test on the newest speed
	assign newest_abs = newest_q[SPEED_W-1] ? SPEED_W'(-newest_q) : SPEED_W'(newest_q);
	assign below_db   = newest_abs < {1'b0, deadband_q};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q   <= esp_pkg::THRESH_RESET;
			deadband_q <= esp_pkg::DEADBAND_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				esp_pkg::CFG_THRESH:   thresh_q   <= cfg.data;
				esp_pkg::CFG_DEADBAND: deadband_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// sequencer and estimator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_edge_q <= '0;
			start_q     <= '0;
			tau_q       <= '0;
			tau_done_q  <= 1'b0;
			head_q      <= '0;
			newest_q    <= '0;
			sum_q       <= '0;
			avg_q       <= '0;
			ts_q        <= '0;
			dir_q       <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ts_q    <= evt.timestamp_us;
						dir_q   <= evt.dir_level;
						state_q <= S_DONE;
						case (evt.req_type)
							esp_pkg::REQ_EDGE: begin
								last_edge_q <= evt.timestamp_us;
								head_q      <= head_nxt;
								state_q     <= S_SPD;
							end
							esp_pkg::REQ_START: start_q <= evt.timestamp_us;
							esp_pkg::REQ_STOP:  tau_done_q <= 1'b0;
							default: ;
						endcase
					end
				end
				S_SPD: begin
					if (div_stat.done) begin
						if (mag >= thresh_q && !tau_done_q) begin
							tau_q      <= ts_q - start_q;
							tau_done_q <= 1'b1;
						end
						newest_q <= spd_new;
						sum_q    <= sum_q + SUM_W'(spd_new) - SUM_W'(ring_old);
						state_q  <= S_SUM;
					end
				end
				S_SUM: state_q <= S_AVG;
				S_AVG: begin
					if (div_stat.done) begin
						avg_q   <= sum_neg ? -avg_mag : avg_mag;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_spd_q      <= newest_q;
			out_db_q       <= below_db ? '0 : newest_q;
			out_avg_q      <= avg_q;
			out_tau_q      <= tau_q;
			out_tau_done_q <= tau_done_q;
		end
	end

	assign res.valid            = out_vld_q;
	assign res.speed_pps        = out_spd_q;
	assign res.speed_deadbanded = out_db_q;
	assign res.average_pps      = out_avg_q;
	assign res.tau_us           = out_tau_q;
	assign res.tau_captured     = out_tau_done_q;

	`ASSERT_CLK(a_div_done_phase,
		div_stat.done |-> (state_q == S_SPD || state_q == S_AVG),
		"divider finished outside a division phase")
	`ASSERT_NEXT(a_edge_divides, accept && is_edge,
		div_stat.busy && state_q == S_SPD, "edge did not start the speed division")
	`ASSERT_CLK(a_tau_clear_stop,
		$fell(tau_done_q) |-> $past(accept && evt.req_type == esp_pkg::REQ_STOP),
		"tau flag cleared without a stop event")

endmodule

### hw/rtl/esp_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on esp_pkg and assert_macros.svh
`include "assert_macros.svh"

module esp_div #(
	parameter int DVD_W = 25,
	parameter int DVS_W = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [DVD_W-1:0]       dividend,
	input  logic [DVS_W-1:0]       divisor,
	output esp_pkg::div_stat_t     stat,
	output logic [DVD_W-1:0]       quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;

	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic           fits;

	// trial subtract of the shifted remainder
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

	`ASSERT_CLK(a_no_restart, start |-> !busy_q, "divider started while busy")
	`ASSERT_NEXT(a_start_busy, start, busy_q && !done_q, "divider did not go busy")

endmodule

### hw/rtl/esp_ring.sv
// speed history ring: one write and one registered read port, per-entry valid
// bits so entries not yet written read as zero; depends on esp_pkg
module esp_ring #(
	parameter int DEPTH  = 10,
	parameter int ADDR_W = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [ADDR_W-1:0]                  wr_addr,
	input  logic signed [esp_pkg::SPEED_W-1:0] wr_data,
	input  logic                               rd_en,
	input  logic [ADDR_W-1:0]                  rd_addr,
	output logic signed [esp_pkg::SPEED_W-1:0] rd_data
);

	logic signed [esp_pkg::SPEED_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]                   vld_q;
	logic signed [esp_pkg::SPEED_W-1:0] rd_q;
	logic                               rd_vld_q;

	// storage write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule
